// File: rtl/sbas_pkg.sv
`default_nettype none

package sbas_pkg;

  // Field widths fixed by the operand format
  localparam int MAG_W = 64;
  localparam int DIG_MAX = MAG_W / 4;
  localparam int SIGN_W = 2;

  // Sign encodings: two-bit two's complement
  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
  localparam logic [SIGN_W-1:0] SIGN_POS = 2'b01;
  localparam logic [SIGN_W-1:0] SIGN_NEG = 2'b11;

  // Operation chosen after sign decode
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_ZERO = 2'd0;
  localparam mode_t MODE_PASS = 2'd1;
  localparam mode_t MODE_ADD = 2'd2;
  localparam mode_t MODE_SUB = 2'd3;

  // Stage 1 -> stage 2: ordered operands (x >= y on subtract)
  typedef struct packed {
    logic valid;
    mode_t mode;
    logic [SIGN_W-1:0] sign;
    logic [MAG_W-1:0] x;
    logic [MAG_W-1:0] y;
  } prep_t;

  // Stage 2 -> stage 3: per-digit carry generate/propagate and both digit candidates
  typedef struct packed {
    logic valid;
    logic add;
    logic [SIGN_W-1:0] sign;
    logic [DIG_MAX-1:0] gen;
    logic [DIG_MAX-1:0] prop;
    logic [MAG_W-1:0] dig0;
    logic [MAG_W-1:0] dig1;
  } digit_t;

endpackage

`default_nettype wire

// File: rtl/sbas_prep.sv
`default_nettype none

module sbas_prep
  import sbas_pkg::*;
#(
  parameter int MAG_DIGITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic accept,
  input wire logic command,
  input wire logic signed [SIGN_W-1:0] sign_a,
  input wire logic [MAG_W-1:0] mag_a,
  input wire logic signed [SIGN_W-1:0] sign_b,
  input wire logic [MAG_W-1:0] mag_b,
  output prep_t prep
);

  localparam int MAG_BITS = 4 * MAG_DIGITS;
  localparam logic [MAG_W-1:0] MAG_MASK = {MAG_W{1'b1}} >> (MAG_W - MAG_BITS);

  logic nz_a;
  logic nz_b;
  logic neg_a;
  logic neg_b;
  logic [SIGN_W-1:0] sgn_a;
  logic [SIGN_W-1:0] sgn_b;
  logic [MAG_W-1:0] ma;
  logic [MAG_W-1:0] mb;
  logic a_gt;
  logic a_eq;
  prep_t prep_next;

  // Decode effective signs, trim magnitudes, compare
  always_comb begin
    nz_a = |sign_a;
    nz_b = |sign_b;
    neg_a = sign_a[1];
    neg_b = sign_b[1] ^ command;
    sgn_a = neg_a ? SIGN_NEG : SIGN_POS;
    sgn_b = neg_b ? SIGN_NEG : SIGN_POS;
    ma = mag_a & MAG_MASK;
    mb = mag_b & MAG_MASK;
    a_gt = ma > mb;
    a_eq = ma == mb;
  end

  // Pick the operation and order the operands
  always_comb begin
    prep_next.valid = accept;
    prep_next.mode = MODE_ZERO;
    prep_next.sign = SIGN_ZERO;
    prep_next.x = '0;
    prep_next.y = '0;
    if (!nz_a && !nz_b) begin
      prep_next.mode = MODE_ZERO;
    end else if (!nz_a) begin
      prep_next.mode = MODE_PASS;
      prep_next.sign = sgn_b;
      prep_next.x = mb;
    end else if (!nz_b) begin
      prep_next.mode = MODE_PASS;
      prep_next.sign = sgn_a;
      prep_next.x = ma;
    end else if (neg_a == neg_b) begin
      prep_next.mode = MODE_ADD;
      prep_next.sign = sgn_a;
      prep_next.x = ma;
      prep_next.y = mb;
    end else if (a_gt) begin
      prep_next.mode = MODE_SUB;
      prep_next.sign = sgn_a;
      prep_next.x = ma;
      prep_next.y = mb;
    end else if (!a_eq) begin
      prep_next.mode = MODE_SUB;
      prep_next.sign = sgn_b;
      prep_next.x = mb;
      prep_next.y = ma;
    end
  end

  // Stage register; clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      prep <= '0;
    end else begin
      prep <= prep_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sbas_digits.sv
`default_nettype none

module sbas_digits
  import sbas_pkg::*;
#(
  parameter int MAG_DIGITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  input prep_t prep,
  output digit_t dig
);

  logic [3:0] dx;
  logic [3:0] dy;
  logic [4:0] s0;
  logic [3:0] diff;
  logic g;
  logic p;
  logic [3:0] d0;
  logic [3:0] d1;
  digit_t dig_next;

  // Per digit: carry/borrow generate and propagate, result for carry-in 0 and 1
  always_comb begin
    dig_next.valid = prep.valid;
    dig_next.add = prep.mode == MODE_ADD;
    dig_next.sign = (prep.mode == MODE_ZERO) ? SIGN_ZERO : prep.sign;
    dig_next.gen = '0;
    dig_next.prop = '0;
    dig_next.dig0 = '0;
    dig_next.dig1 = '0;
    for (int i = 0; i < DIG_MAX; i++) begin
      dx = prep.x[4*i +: 4];
      dy = prep.y[4*i +: 4];
      s0 = {1'b0, dx} + {1'b0, dy};
      diff = dx - dy;
      g = 1'b0;
      p = 1'b0;
      d0 = '0;
      d1 = '0;
      case (prep.mode)
        MODE_ADD: begin
          g = s0 > 5'd9;
          p = s0 == 5'd9;
          d0 = g ? 4'(s0 - 5'd10) : s0[3:0];
          d1 = (g | p) ? 4'(s0 - 5'd9) : 4'(s0 + 5'd1);
        end
        MODE_SUB: begin
          g = dx < dy;
          p = dx == dy;
          d0 = g ? diff + 4'd10 : diff;
          d1 = (g | p) ? diff + 4'd9 : diff - 4'd1;
        end
        MODE_PASS: begin
          d0 = dx;
          d1 = dx;
        end
        default: begin
          d0 = '0;
          d1 = '0;
        end
      endcase
      if (i < MAG_DIGITS) begin
        dig_next.gen[i] = g;
        dig_next.prop[i] = p;
        dig_next.dig0[4*i +: 4] = d0;
        dig_next.dig1[4*i +: 4] = d1;
      end
    end
  end

  // Stage register; clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      dig <= '0;
    end else begin
      dig <= dig_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sbas_resolve.sv
`default_nettype none

module sbas_resolve
  import sbas_pkg::*;
#(
  parameter int MAG_DIGITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  input digit_t dig,
  output logic done,
  output logic signed [SIGN_W-1:0] result_sign,
  output logic [MAG_W-1:0] result_mag,
  output logic overflow
);

  localparam int MAG_BITS = 4 * MAG_DIGITS;
  localparam logic [MAG_W-1:0] MAG_MASK = {MAG_W{1'b1}} >> (MAG_W - MAG_BITS);

  logic [DIG_MAX-1:0] gp;
  logic [DIG_MAX:0] csum;
  logic [DIG_MAX:0] cin;
  logic [MAG_W-1:0] mag_next;

  // Resolve digit carries with one binary add over generate/propagate
  always_comb begin
    gp = dig.gen | dig.prop;
    csum = {1'b0, dig.gen} + {1'b0, gp};
    cin = csum ^ {1'b0, dig.gen} ^ {1'b0, gp};
  end

  // Select each digit by its carry-in, drop unused nibbles
  always_comb begin
    mag_next = '0;
    for (int i = 0; i < DIG_MAX; i++) begin
      mag_next[4*i +: 4] = cin[i] ? dig.dig1[4*i +: 4] : dig.dig0[4*i +: 4];
    end
    mag_next = mag_next & MAG_MASK;
  end

  // Output registers
  always_ff @(posedge clk) begin
    result_sign <= dig.sign;
    result_mag <= mag_next;
    overflow <= dig.add & cin[MAG_DIGITS];
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dig.valid;
    end
  end

endmodule

`default_nettype wire

// File: rtl/signed_bcd_add_sub_unit.sv
`default_nettype none

// Signed decimal add/subtract unit.
// Operands are sign (-1, 0, +1; 0 means zero) plus packed BCD magnitude of
// MAG_DIGITS digits. command 0 computes a + b, command 1 computes a - b.
// A transaction is taken at a rising edge where start is high and busy is
// low; busy is always low, so one transaction can enter every cycle.
// Pipeline: three register stages (sign decode and magnitude compare, digit
// sums/differences, decimal carry resolve). done is high for one cycle when
// a transaction leaves the last stage, with result_sign, result_mag and
// overflow valid in that same cycle only.
// Throughput: one transaction per cycle; the fixed pipeline sets the latency.
// overflow flags a decimal carry out of the top digit on addition; the
// magnitude then wraps. Equal magnitudes of unlike sign give sign 0.
// Reset clears the stage valid bits, so no done strobe follows reset until
// a new transaction enters. The receiver cannot stall: every result is
// presented exactly once.
module signed_bcd_add_sub_unit
  import sbas_pkg::*;
#(
  parameter int MAG_DIGITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire logic command,
  input wire logic signed [SIGN_W-1:0] sign_a,
  input wire logic [MAG_W-1:0] mag_a,
  input wire logic signed [SIGN_W-1:0] sign_b,
  input wire logic [MAG_W-1:0] mag_b,
  output logic done,
  output logic signed [SIGN_W-1:0] result_sign,
  output logic [MAG_W-1:0] result_mag,
  output logic overflow
);

  prep_t prep;
  digit_t dig;
  logic accept;

  // Fully pipelined: never hold off a transaction
  assign busy = 1'b0;
  assign accept = start & ~busy;

  sbas_prep #(
    .MAG_DIGITS(MAG_DIGITS)
  ) u_prep (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .command(command),
    .sign_a(sign_a),
    .mag_a(mag_a),
    .sign_b(sign_b),
    .mag_b(mag_b),
    .prep(prep)
  );

  sbas_digits #(
    .MAG_DIGITS(MAG_DIGITS)
  ) u_digits (
    .clk(clk),
    .rst(rst),
    .prep(prep),
    .dig(dig)
  );

  sbas_resolve #(
    .MAG_DIGITS(MAG_DIGITS)
  ) u_resolve (
    .clk(clk),
    .rst(rst),
    .dig(dig),
    .done(done),
    .result_sign(result_sign),
    .result_mag(result_mag),
    .overflow(overflow)
  );

endmodule

`default_nettype wire
